// ===== src/sspq_pkg.sv =====
// Shared types for the stable sorted priority queue.
// Operation and status codes used by the queue top level and its bench.
// No dependencies.
`default_nettype none

package sspq_pkg;

  typedef enum logic [1:0] {
    KIND_ENQ = 2'd0,
    KIND_REM = 2'd1,
    KIND_CLR = 2'd2,
    KIND_NOP = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_ALREADY    = 2'd1,
    ST_NOT_QUEUED = 2'd2
  } status_e;

  localparam int unsigned CfgAddrW = 3;

  typedef enum logic [CfgAddrW-1:0] {
    REG_PRIORITIZED = 3'd0,
    REG_ASCENDING   = 3'd4
  } reg_addr_e;

endpackage

`default_nettype wire

// ===== src/sspq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for the per-entry priority and link stores. No dependencies.
`default_nettype none

module sspq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== src/stable_sorted_priority_queue.sv =====
// Channel   | Handshake              | Payload
// ----------+------------------------+-----------------------------------------------
// command   | start / busy           | kind_i, entry_id_i, priority_req_i
// result    | done_o (one-cycle)     | status_o, head_valid_o, head_id_o,
//           |                        | head_priority_o, count_o
// config    | APB psel/penable/pready| paddr, pwdata, prdata (0: prioritized, 4: ascending)
//
// A command beat is taken when start is high and busy is low; its result beat follows
// once its state sequence ends. Enqueue runs CHECK, WALK (skipped on an empty queue),
// LINK, FIX and RESP; the walk reads one list node per cycle from the link RAMs.
// Remove runs CHECK, RMV, HPRI (only when the head moves) and RESP; clear, no-op and
// ignored commands run CHECK and RESP. busy drops the cycle after the result beat.
// Reset (rst_ni, asynchronous) empties the queue at once. Results cannot be stalled.
// Depends on sspq_pkg and sspq_ram.
`default_nettype none

module stable_sorted_priority_queue #(
  parameter int unsigned ENTRIES         = 16,
  parameter int unsigned PRIORITY_BITS   = 8,
  parameter int unsigned LOWEST_PRIORITY = 1
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Command channel
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [1:0]                        kind_i,
  input  wire logic [3:0]                        entry_id_i,
  input  wire logic [7:0]                        priority_req_i,
  // Result channel
  output logic                                   done_o,
  output logic [1:0]                             status_o,
  output logic                                   head_valid_o,
  output logic [3:0]                             head_id_o,
  output logic [7:0]                             head_priority_o,
  output logic [4:0]                             count_o,
  // Configuration port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [sspq_pkg::CfgAddrW-1:0]     paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);

  import sspq_pkg::*;

  localparam int unsigned IdxW  = $clog2(ENTRIES);
  localparam int unsigned LinkW = $clog2(ENTRIES + 1);
  localparam int unsigned CntW  = $clog2(ENTRIES + 1);
  localparam logic [LinkW-1:0]         Nil    = LinkW'(ENTRIES);
  localparam logic [PRIORITY_BITS-1:0] LowPri = PRIORITY_BITS'(LOWEST_PRIORITY);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CHECK = 8'b0000_0010,
    S_WALK  = 8'b0000_0100,
    S_LINK  = 8'b0000_1000,
    S_FIX   = 8'b0001_0000,
    S_RMV   = 8'b0010_0000,
    S_HPRI  = 8'b0100_0000,
    S_RESP  = 8'b1000_0000
  } state_e;

  state_e                   state_q, state_d;
  kind_e                    kind_q, kind_d;
  logic [3:0]               id_q, id_d;
  logic [PRIORITY_BITS-1:0] pri_q, pri_d;
  logic [IdxW-1:0]          it_q, it_d;
  logic [LinkW-1:0]         pl_q, pl_d;
  logic [LinkW-1:0]         nl_q, nl_d;
  status_e                  status_q, status_d;
  logic                     head_valid_q, head_valid_d;
  logic [IdxW-1:0]          head_idx_q, head_idx_d;
  logic [PRIORITY_BITS-1:0] head_prio_q, head_prio_d;
  logic [CntW-1:0]          count_q, count_d;
  logic [ENTRIES-1:0]       queued_q, queued_d;
  logic                     prioritized_q, ascending_q;

  logic                     id_ok;
  logic [IdxW-1:0]          id_idx;
  logic [LinkW-1:0]         id_link;
  logic                     beats;
  logic                     cfg_wr;

  // Link and priority stores; all three share one read address.
  logic [IdxW-1:0]          rd_addr;
  logic [PRIORITY_BITS-1:0] prio_rd;
  logic [LinkW-1:0]         next_rd, prev_rd;
  logic                     prio_we, next_we, prev_we;
  logic [IdxW-1:0]          prio_waddr, next_waddr, prev_waddr;
  logic [PRIORITY_BITS-1:0] prio_wdata;
  logic [LinkW-1:0]         next_wdata, prev_wdata;

  sspq_ram #(.WIDTH(PRIORITY_BITS), .DEPTH(ENTRIES)) u_prio_ram (
    .clk_i   (clk_i),
    .we_i    (prio_we),
    .waddr_i (prio_waddr),
    .wdata_i (prio_wdata),
    .raddr_i (rd_addr),
    .rdata_o (prio_rd)
  );

  sspq_ram #(.WIDTH(LinkW), .DEPTH(ENTRIES)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .raddr_i (rd_addr),
    .rdata_o (next_rd)
  );

  sspq_ram #(.WIDTH(LinkW), .DEPTH(ENTRIES)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_we),
    .waddr_i (prev_waddr),
    .wdata_i (prev_wdata),
    .raddr_i (rd_addr),
    .rdata_o (prev_rd)
  );

  assign busy    = (state_q != S_IDLE);
  assign id_ok   = (32'(id_q) < 32'(ENTRIES));
  assign id_idx  = IdxW'(id_q);
  assign id_link = LinkW'(id_idx);

  // The single comparator of the walk: strict, so equal priorities stay in arrival order.
  assign beats = ascending_q ? (pri_q < prio_rd) : (pri_q > prio_rd);

  // The walk follows the registered next link straight into the read address.
  always_comb begin
    if (state_q == S_CHECK) begin
      rd_addr = (kind_q == KIND_ENQ) ? head_idx_q : id_idx;
    end else begin
      rd_addr = IdxW'(next_rd);
    end
  end

  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    id_d         = id_q;
    pri_d        = pri_q;
    it_d         = it_q;
    pl_d         = pl_q;
    nl_d         = nl_q;
    status_d     = status_q;
    head_valid_d = head_valid_q;
    head_idx_d   = head_idx_q;
    head_prio_d  = head_prio_q;
    count_d      = count_q;
    queued_d     = queued_q;
    prio_we      = 1'b0;
    prio_waddr   = id_idx;
    prio_wdata   = pri_q;
    next_we      = 1'b0;
    next_waddr   = id_idx;
    next_wdata   = nl_q;
    prev_we      = 1'b0;
    prev_waddr   = id_idx;
    prev_wdata   = pl_q;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          kind_d  = kind_e'(kind_i);
          id_d    = entry_id_i;
          pri_d   = prioritized_q ? PRIORITY_BITS'(priority_req_i) : LowPri;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        status_d = ST_DONE;
        unique case (kind_q)
          KIND_ENQ: begin
            if (!id_ok) begin
              status_d = ST_NOT_QUEUED;
              state_d  = S_RESP;
            end else if (queued_q[id_idx]) begin
              status_d = ST_ALREADY;
              state_d  = S_RESP;
            end else begin
              prio_we = 1'b1;
              if (head_valid_q) begin
                it_d    = head_idx_q;
                state_d = S_WALK;
              end else begin
                pl_d    = Nil;
                nl_d    = Nil;
                state_d = S_LINK;
              end
            end
          end
          KIND_REM: begin
            if (!id_ok || !queued_q[id_idx] || (count_q == '0)) begin
              status_d = ST_NOT_QUEUED;
              state_d  = S_RESP;
            end else begin
              state_d = S_RMV;
            end
          end
          KIND_CLR: begin
            queued_d     = '0;
            head_valid_d = 1'b0;
            count_d      = '0;
            state_d      = S_RESP;
          end
          KIND_NOP: begin
            state_d = S_RESP;
          end
        endcase
      end
      S_WALK: begin
        // Read data here belongs to node it_q.
        if (beats) begin
          pl_d    = prev_rd;
          nl_d    = LinkW'(it_q);
          state_d = S_LINK;
        end else if (next_rd >= Nil) begin
          pl_d    = LinkW'(it_q);
          nl_d    = Nil;
          state_d = S_LINK;
        end else begin
          it_d = IdxW'(next_rd);
        end
      end
      S_LINK: begin
        next_we = 1'b1;
        prev_we = 1'b1;
        if (pl_q >= Nil) begin
          head_valid_d = 1'b1;
          head_idx_d   = id_idx;
          head_prio_d  = pri_q;
        end
        count_d          = count_q + CntW'(1);
        queued_d[id_idx] = 1'b1;
        state_d          = S_FIX;
      end
      S_FIX: begin
        // Point the neighbors at the new node.
        next_waddr = IdxW'(pl_q);
        next_wdata = id_link;
        next_we    = (pl_q < Nil);
        prev_waddr = IdxW'(nl_q);
        prev_wdata = id_link;
        prev_we    = (nl_q < Nil);
        state_d    = S_RESP;
      end
      S_RMV: begin
        prev_waddr       = IdxW'(next_rd);
        prev_wdata       = prev_rd;
        prev_we          = (next_rd < Nil);
        next_waddr       = IdxW'(prev_rd);
        next_wdata       = next_rd;
        next_we          = (prev_rd < Nil);
        queued_d[id_idx] = 1'b0;
        count_d          = count_q - CntW'(1);
        if (head_valid_q && (head_idx_q == id_idx)) begin
          if (next_rd < Nil) begin
            // The read issued this cycle fetches the new head's priority.
            head_idx_d = IdxW'(next_rd);
            state_d    = S_HPRI;
          end else begin
            head_valid_d = 1'b0;
            state_d      = S_RESP;
          end
        end else begin
          state_d = S_RESP;
        end
      end
      S_HPRI: begin
        head_prio_d = prio_rd;
        state_d     = S_RESP;
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      status_q      <= ST_DONE;
      head_valid_q  <= 1'b0;
      count_q       <= '0;
      queued_q      <= '0;
      prioritized_q <= 1'b1;
      ascending_q   <= 1'b1;
    end else begin
      state_q      <= state_d;
      status_q     <= status_d;
      head_valid_q <= head_valid_d;
      count_q      <= count_d;
      queued_q     <= queued_d;
      if (cfg_wr) begin
        if (paddr[2] == REG_ASCENDING[2]) begin
          ascending_q <= pwdata[0];
        end else begin
          prioritized_q <= pwdata[0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    id_q        <= id_d;
    pri_q       <= pri_d;
    it_q        <= it_d;
    pl_q        <= pl_d;
    nl_q        <= nl_d;
    head_idx_q  <= head_idx_d;
    head_prio_q <= head_prio_d;
  end

  assign pready = 1'b1;
  assign prdata = {31'b0, (paddr[2] == REG_ASCENDING[2]) ? ascending_q : prioritized_q};

  assign done_o          = (state_q == S_RESP);
  assign status_o        = status_q;
  assign head_valid_o    = head_valid_q;
  assign head_id_o       = head_valid_q ? 4'(head_idx_q) : 4'd0;
  assign head_priority_o = head_valid_q ? 8'(head_prio_q) : 8'd0;
  assign count_o         = 5'(count_q);

endmodule

`default_nettype wire

// ===== src/sspq_checker.sv =====
// Port-level checker for the stable sorted priority queue, bound to its top level.
// Depends on sspq_pkg and stable_sorted_priority_queue.
`default_nettype none

module sspq_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       done_o,
  input wire logic       head_valid_o,
  input wire logic [3:0] head_id_o,
  input wire logic [7:0] head_priority_o,
  input wire logic [4:0] count_o
);

  import sspq_pkg::*;

  // A taken command always occupies the block in the following cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("command beat taken but block not busy afterwards");

  // A result beat only comes out of a command in flight.
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(busy) && busy))
    else $error("result beat without a command in flight");

  // Exactly one result beat per command.
  a_single_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!done_o && !busy))
    else $error("result beat repeated or block stayed busy");

  // An empty queue reports a zero head and a zero count.
  a_empty_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !head_valid_o) |->
      ((head_id_o == 4'd0) && (head_priority_o == 8'd0) && (count_o == 5'd0)))
    else $error("empty queue reported with nonzero head or count");

endmodule

bind stable_sorted_priority_queue sspq_checker u_sspq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .done_o          (done_o),
  .head_valid_o    (head_valid_o),
  .head_id_o       (head_id_o),
  .head_priority_o (head_priority_o),
  .count_o         (count_o)
);

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for the stable sorted priority queue: a directed script, then
// randomized phases under every ordering mode, each result checked against a predictor.
// Depends on sspq_pkg and the stable_sorted_priority_queue top level.
module tb_top;
  import sspq_pkg::*;

  localparam int unsigned ENTRIES = 16;
  localparam logic [4:0] NIL = 5'd16;
  localparam logic [7:0] LOWEST_PRIO = 8'd1;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 110;

  typedef struct packed {
    status_e     status;
    logic        head_valid;
    logic [3:0]  head_id;
    logic [7:0]  head_prio;
    logic [4:0]  count;
  } queue_report_t;

  typedef struct {
    kind_e         kind;
    logic [3:0]    id;
    logic [7:0]    prio;
    bit            typed;
    queue_report_t report;
  } script_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  kind_i = '0;
  logic [3:0]  entry_id_i = '0;
  logic [7:0]  priority_req_i = '0;
  logic        done_o;
  logic [1:0]  status_o;
  logic        head_valid_o;
  logic [3:0]  head_id_o;
  logic [7:0]  head_priority_o;
  logic [4:0]  count_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predicted queue contents and mode bits.
  logic [7:0]  slot_prio [ENTRIES];
  logic [4:0]  slot_next [ENTRIES];
  logic [4:0]  slot_prev [ENTRIES];
  logic [15:0] slot_queued = '0;
  logic [4:0]  list_head = NIL;
  logic [4:0]  list_len = '0;
  logic        cfg_prioritized = 1'b1;
  logic        cfg_ascending = 1'b1;

  queue_report_t pending_reports [$];
  script_row_t   script [$];
  int unsigned   errors = 0;
  int unsigned   cycles = 0;
  bit            idle_on = 1'b1;

  stable_sorted_priority_queue uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .kind_i          (kind_i),
    .entry_id_i      (entry_id_i),
    .priority_req_i  (priority_req_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .head_valid_o    (head_valid_o),
    .head_id_o       (head_id_o),
    .head_priority_o (head_priority_o),
    .count_o         (count_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_reports.size());
      $display("** stable_sorted_priority_queue: FAILED **");
      $finish;
    end
  end

  function automatic queue_report_t rep(status_e st, logic hv, logic [3:0] hid,
                                        logic [7:0] hp, logic [4:0] cnt);
    queue_report_t r;
    r.status = st;
    r.head_valid = hv;
    r.head_id = hid;
    r.head_prio = hp;
    r.count = cnt;
    return r;
  endfunction

  function automatic void add_row(kind_e k, logic [3:0] id, logic [7:0] prio, bit typed,
                                  queue_report_t r);
    script_row_t row;
    row.kind = k;
    row.id = id;
    row.prio = prio;
    row.typed = typed;
    row.report = r;
    script.push_back(row);
  endfunction

  // Applies one command to the predicted list and returns the report it produces.
  function automatic queue_report_t apply_command(kind_e k, logic [3:0] id, logic [7:0] prio);
    queue_report_t r;
    logic [4:0] it;
    logic [4:0] p;
    logic       placed;
    r = '0;
    r.status = ST_DONE;
    case (k)
      KIND_ENQ: begin
        if (slot_queued[id]) begin
          r.status = ST_ALREADY;
        end else begin
          if (!cfg_prioritized) prio = LOWEST_PRIO;
          slot_prio[id] = prio;
          if (list_head == NIL) begin
            list_head = {1'b0, id};
            slot_next[id] = NIL;
            slot_prev[id] = NIL;
          end else begin
            it = list_head;
            placed = 1'b0;
            // The new entry goes before the first entry it strictly beats, so ties
            // keep arrival order.
            for (int s = 0; s < ENTRIES && !placed; s++) begin
              if (cfg_ascending ? (prio < slot_prio[it[3:0]])
                                : (prio > slot_prio[it[3:0]])) begin
                p = slot_prev[it[3:0]];
                slot_prev[id] = p;
                slot_next[id] = it;
                if (p != NIL) slot_next[p[3:0]] = {1'b0, id};
                slot_prev[it[3:0]] = {1'b0, id};
                if (list_head == it) list_head = {1'b0, id};
                placed = 1'b1;
              end else if (slot_next[it[3:0]] == NIL) begin
                slot_next[id] = NIL;
                slot_prev[id] = it;
                slot_next[it[3:0]] = {1'b0, id};
                placed = 1'b1;
              end else begin
                it = slot_next[it[3:0]];
              end
            end
          end
          list_len = list_len + 5'd1;
          slot_queued[id] = 1'b1;
        end
      end
      KIND_REM: begin
        if (!slot_queued[id] || list_len == 0) begin
          r.status = ST_NOT_QUEUED;
        end else begin
          it = slot_next[id];
          p = slot_prev[id];
          if (it != NIL) slot_prev[it[3:0]] = p;
          if (p != NIL) slot_next[p[3:0]] = it;
          if (list_head == {1'b0, id}) list_head = it;
          list_len = list_len - 5'd1;
          slot_queued[id] = 1'b0;
        end
      end
      KIND_CLR: begin
        slot_queued = '0;
        list_head = NIL;
        list_len = '0;
      end
      default: ;
    endcase
    if (list_head != NIL) begin
      r.head_valid = 1'b1;
      r.head_id = list_head[3:0];
      r.head_prio = slot_prio[list_head[3:0]];
    end
    r.count = list_len;
    return r;
  endfunction

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    queue_report_t want;
    if (rst_ni && done_o) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: result beat with nothing expected, status %0d head %0d/%0d count %0d",
                 $time, status_o, head_id_o, head_priority_o, count_o);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        check_field("status", want.status, status_o);
        check_field("head_valid", want.head_valid, head_valid_o);
        check_field("head_id", want.head_id, head_id_o);
        check_field("head_priority", want.head_prio, head_priority_o);
        check_field("count", want.count, count_o);
      end
    end
  end

  // Presents one command beat and records its expected report once it is taken.
  task automatic send_command(input kind_e k, input logic [3:0] id, input logic [7:0] prio,
                              input bit typed, input queue_report_t typed_report);
    queue_report_t want;
    if (idle_on && $urandom_range(0, 99) < 37) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
    end
    start <= 1'b1;
    kind_i <= k;
    entry_id_i <= id;
    priority_req_i <= prio;
    do @(posedge clk_i); while (busy);
    want = apply_command(k, id, prio);
    if (typed) want = typed_report;
    pending_reports.push_back(want);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_reports.size() != 0 || busy) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // One full transfer; the bus returns to idle before the next one starts.
  task automatic apb_cycle(input bit wr, input reg_addr_e addr, input logic [31:0] wdata,
                           output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_mode(input logic prio_on, input logic asc_on);
    logic [31:0] rdata;
    apb_cycle(1'b1, REG_PRIORITIZED, {31'd0, prio_on}, rdata);
    apb_cycle(1'b1, REG_ASCENDING, {31'd0, asc_on}, rdata);
    cfg_prioritized = prio_on;
    cfg_ascending = asc_on;
    apb_cycle(1'b0, REG_PRIORITIZED, '0, rdata);
    check_field("prioritized readback", {31'd0, prio_on}, rdata);
    apb_cycle(1'b0, REG_ASCENDING, '0, rdata);
    check_field("ascending readback", {31'd0, asc_on}, rdata);
  endtask

  function automatic logic [3:0] pick_id(bit want_queued);
    logic [3:0] cand [$];
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_queued[i] == want_queued) cand.push_back(i[3:0]);
    end
    if (cand.size() == 0) return 4'($urandom_range(0, 15));
    return cand[$urandom_range(0, cand.size() - 1)];
  endfunction

  task automatic run_phase(input int unsigned items, input int unsigned enq_pct);
    int unsigned roll;
    kind_e       k;
    logic [3:0]  id;
    logic [7:0]  prio;
    for (int n = 0; n < items; n++) begin
      roll = $urandom_range(0, 99);
      id = 4'($urandom_range(0, 15));
      case ($urandom_range(0, 3))
        0: prio = 8'($urandom_range(0, 3));
        1: prio = $urandom_range(0, 1) ? 8'hff : 8'h00;
        default: prio = 8'($urandom());
      endcase
      // Mostly well-formed traffic: enqueue free ids and remove queued ones.
      if (roll < enq_pct) begin
        k = KIND_ENQ;
        if ($urandom_range(0, 99) < 85) id = pick_id(1'b0);
      end else if (roll < 95) begin
        k = KIND_REM;
        if ($urandom_range(0, 99) < 85) id = pick_id(1'b1);
      end else if (roll < 97) begin
        k = KIND_CLR;
      end else begin
        k = KIND_NOP;
      end
      send_command(k, id, prio, 1'b0, '0);
    end
  endtask

  initial begin
    logic prio_on;
    logic asc_on;
    foreach (slot_prio[i]) begin
      slot_prio[i] = '0;
      slot_next[i] = '0;
      slot_prev[i] = '0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset mode: prioritized, smallest value first.
    add_row(KIND_REM, 4'd5, 8'd0, 1, rep(ST_NOT_QUEUED, 0, 4'd0, 8'd0, 5'd0));
    add_row(KIND_NOP, 4'd9, 8'd200, 1, rep(ST_DONE, 0, 4'd0, 8'd0, 5'd0));
    add_row(KIND_CLR, 4'd0, 8'd0, 1, rep(ST_DONE, 0, 4'd0, 8'd0, 5'd0));
    add_row(KIND_ENQ, 4'd0, 8'd255, 1, rep(ST_DONE, 1, 4'd0, 8'd255, 5'd1));
    add_row(KIND_ENQ, 4'd0, 8'd3, 1, rep(ST_ALREADY, 1, 4'd0, 8'd255, 5'd1));
    add_row(KIND_ENQ, 4'd15, 8'd0, 1, rep(ST_DONE, 1, 4'd15, 8'd0, 5'd2));
    add_row(KIND_ENQ, 4'd7, 8'd0, 1, rep(ST_DONE, 1, 4'd15, 8'd0, 5'd3));
    add_row(KIND_ENQ, 4'd3, 8'd128, 0, '0);
    add_row(KIND_ENQ, 4'd9, 8'd128, 0, '0);
    add_row(KIND_ENQ, 4'd12, 8'd255, 0, '0);
    add_row(KIND_REM, 4'd15, 8'd0, 0, '0);
    add_row(KIND_REM, 4'd9, 8'd0, 0, '0);
    add_row(KIND_REM, 4'd12, 8'd0, 0, '0);
    add_row(KIND_REM, 4'd12, 8'd0, 0, '0);
    add_row(KIND_NOP, 4'd10, 8'd77, 0, '0);
    add_row(KIND_ENQ, 4'd5, 8'd0, 0, '0);
    add_row(KIND_ENQ, 4'd6, 8'd255, 0, '0);
    add_row(KIND_CLR, 4'd0, 8'd0, 1, rep(ST_DONE, 0, 4'd0, 8'd0, 5'd0));
    add_row(KIND_REM, 4'd0, 8'd0, 1, rep(ST_NOT_QUEUED, 0, 4'd0, 8'd0, 5'd0));
    add_row(KIND_ENQ, 4'd15, 8'd255, 1, rep(ST_DONE, 1, 4'd15, 8'd255, 5'd1));
    add_row(KIND_ENQ, 4'd1, 8'd255, 0, '0);
    add_row(KIND_ENQ, 4'd2, 8'd0, 0, '0);
    add_row(KIND_REM, 4'd1, 8'd0, 0, '0);
    add_row(KIND_CLR, 4'd0, 8'd0, 1, rep(ST_DONE, 0, 4'd0, 8'd0, 5'd0));
    foreach (script[i]) begin
      send_command(script[i].kind, script[i].id, script[i].prio, script[i].typed,
                   script[i].report);
    end

    // The first four phases sweep every mode combination; the rest pick at random.
    // The queue is left as it is across mode changes.
    for (int p = 0; p < PHASES; p++) begin
      drain();
      if (p < 4) begin
        prio_on = !p[1];
        asc_on = !p[0];
      end else begin
        prio_on = 1'($urandom_range(0, 1));
        asc_on = 1'($urandom_range(0, 1));
      end
      set_mode(prio_on, asc_on);
      idle_on = (p != 3);
      run_phase(PHASE_ITEMS, $urandom_range(45, 80));
    end

    drain();
    repeat (30) @(posedge clk_i);
    if (errors == 0) begin
      $display("** stable_sorted_priority_queue: PASSED **");
    end else begin
      $display("** stable_sorted_priority_queue: FAILED **");
    end
    $finish;
  end

endmodule
